>>> sv/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is high.
`define CPTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that is also checked across reset.
`define CPTS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/cpts_pkg.sv
// ----------------------------------------------------------------------------
// cpts_pkg
// Widths, types and constants of the segment closest-point pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package cpts_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 16;

  localparam int DIFF_W  = COORD_BITS + 1;
  localparam int SQ_W    = 2 * DIFF_W;
  localparam int DOT_W   = 2 * DIFF_W + 1;
  localparam int WIDE_W  = 2 * DOT_W;
  localparam int DIV_W   = WIDE_W + 2;
  localparam int Q_W     = FRAC_BITS + 1;
  localparam int BS_W    = DOT_W + Q_W + 1;
  localparam int TN_W    = BS_W + 1;
  localparam int PROD_W  = DIFF_W + Q_W + 1;
  localparam int DIST_W  = 2 * COORD_BITS + 1;
  localparam int DIV_LAT = FRAC_BITS + 1;

  localparam logic [Q_W-1:0] Q_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [DOT_W-1:0]      dot_t;
  typedef logic signed [DIV_W-1:0]      divw_t;
  typedef logic [Q_W-1:0]               param_t;

  typedef struct packed {
    coord_t ax0;
    coord_t ay0;
    coord_t bx0;
    coord_t by0;
    diff_t  d1x;
    diff_t  d1y;
    diff_t  d2x;
    diff_t  d2y;
    diff_t  rx;
    diff_t  ry;
    dot_t   a;
    dot_t   e;
    dot_t   b;
    dot_t   c;
    dot_t   f;
    logic   a_zero;
    logic   e_zero;
    logic   tn_neg;
    logic   tn_gt;
    param_t s_nc;
    param_t s_bc;
    param_t t_f;
    param_t s_main;
  } ctx_t;

endpackage

`default_nettype wire

>>> sv/closest_points_two_segments_unit.sv
// ----------------------------------------------------------------------------
// closest_points_two_segments_unit
// Closest points between two 2D segments and their squared distance.
// ----------------------------------------------------------------------------
// The unit takes one segment pair per cycle while the output is not stalled.
// Its depth comes from two pipelined restoring dividers in series (one step
// per stage): the first finds s, the second finds t from the s it produced.
// All stages advance together; while a result waits at the output, the whole
// pipe holds and in_ready is low, so nothing is lost or repeated.
`default_nettype none

module closest_points_two_segments_unit import cpts_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  coord_t                seg_a_start_x,
  input  coord_t                seg_a_start_y,
  input  coord_t                seg_a_end_x,
  input  coord_t                seg_a_end_y,
  input  coord_t                seg_b_start_x,
  input  coord_t                seg_b_start_y,
  input  coord_t                seg_b_end_x,
  input  coord_t                seg_b_end_y,
  output logic                  out_valid,
  input  logic                  out_ready,
  output coord_t                near_a_x,
  output coord_t                near_a_y,
  output coord_t                near_b_x,
  output coord_t                near_b_y,
  output logic [DIST_W-1:0]     dist_sq
);

  localparam int NSTG = 14 + 2 * DIV_LAT;

  logic            adv;
  logic [NSTG-1:0] vld;

  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NSTG-2:0], in_valid};
    end
  end

  // stage 1: differences
  ctx_t c1, n1;
  always_comb begin
    n1     = '0;
    n1.ax0 = seg_a_start_x;
    n1.ay0 = seg_a_start_y;
    n1.bx0 = seg_b_start_x;
    n1.by0 = seg_b_start_y;
    n1.d1x = diff_t'(seg_a_end_x) - diff_t'(seg_a_start_x);
    n1.d1y = diff_t'(seg_a_end_y) - diff_t'(seg_a_start_y);
    n1.d2x = diff_t'(seg_b_end_x) - diff_t'(seg_b_start_x);
    n1.d2y = diff_t'(seg_b_end_y) - diff_t'(seg_b_start_y);
    n1.rx  = diff_t'(seg_a_start_x) - diff_t'(seg_b_start_x);
    n1.ry  = diff_t'(seg_a_start_y) - diff_t'(seg_b_start_y);
  end
  always_ff @(posedge clk) if (adv) c1 <= n1;

  // stage 2: component products
  ctx_t c2;
  logic signed [SQ_W-1:0] p_ax, p_ay, p_ex, p_ey, p_bx, p_by, p_cx, p_cy, p_fx, p_fy;
  always_ff @(posedge clk) begin
    if (adv) begin
      c2   <= c1;
      p_ax <= c1.d1x * c1.d1x;
      p_ay <= c1.d1y * c1.d1y;
      p_ex <= c1.d2x * c1.d2x;
      p_ey <= c1.d2y * c1.d2y;
      p_bx <= c1.d1x * c1.d2x;
      p_by <= c1.d1y * c1.d2y;
      p_cx <= c1.d1x * c1.rx;
      p_cy <= c1.d1y * c1.ry;
      p_fx <= c1.d2x * c1.rx;
      p_fy <= c1.d2y * c1.ry;
    end
  end

  // stage 3: dot products
  ctx_t c3, n3;
  always_comb begin
    n3        = c2;
    n3.a      = dot_t'(p_ax) + dot_t'(p_ay);
    n3.e      = dot_t'(p_ex) + dot_t'(p_ey);
    n3.b      = dot_t'(p_bx) + dot_t'(p_by);
    n3.c      = dot_t'(p_cx) + dot_t'(p_cy);
    n3.f      = dot_t'(p_fx) + dot_t'(p_fy);
    n3.a_zero = (n3.a == 0);
    n3.e_zero = (n3.e == 0);
  end
  always_ff @(posedge clk) if (adv) c3 <= n3;

  // stage 4: wide products
  ctx_t c4;
  logic signed [WIDE_W-1:0] w_ae, w_bb, w_bf, w_ce;
  always_ff @(posedge clk) begin
    if (adv) begin
      c4   <= c3;
      w_ae <= c3.a * c3.e;
      w_bb <= c3.b * c3.b;
      w_bf <= c3.b * c3.f;
      w_ce <= c3.c * c3.e;
    end
  end

  // stage 5: divider operands
  ctx_t  c5;
  divw_t den_c;
  divw_t v_num, v_den, v_nc, v_bc, v_f, v_a, v_e;
  assign den_c = divw_t'(w_ae) - divw_t'(w_bb);
  always_ff @(posedge clk) begin
    if (adv) begin
      c5    <= c4;
      v_den <= den_c;
      // non-positive denominator: force s to zero
      v_num <= (den_c <= 0) ? divw_t'(0) : divw_t'(w_bf) - divw_t'(w_ce);
      v_nc  <= -divw_t'(c4.c);
      v_bc  <= divw_t'(c4.b) - divw_t'(c4.c);
      v_f   <= divw_t'(c4.f);
      v_a   <= divw_t'(c4.a);
      v_e   <= divw_t'(c4.e);
    end
  end

  param_t q_main, q_nc, q_bc, q_f, q_t;

  cpts_div u_div_main (.clk(clk), .en(adv), .num(v_num), .den(v_den), .quo(q_main));
  cpts_div u_div_nc   (.clk(clk), .en(adv), .num(v_nc),  .den(v_a),   .quo(q_nc));
  cpts_div u_div_bc   (.clk(clk), .en(adv), .num(v_bc),  .den(v_a),   .quo(q_bc));
  cpts_div u_div_f    (.clk(clk), .en(adv), .num(v_f),   .den(v_e),   .quo(q_f));

  ctx_t dly1 [DIV_LAT];
  always_ff @(posedge clk) begin
    if (adv) begin
      dly1[0] <= c5;
      for (int i = 1; i < DIV_LAT; i++) dly1[i] <= dly1[i-1];
    end
  end

  // stage 6: collect ratios
  ctx_t c6, n6;
  always_comb begin
    n6        = dly1[DIV_LAT-1];
    n6.s_main = q_main;
    n6.s_nc   = q_nc;
    n6.s_bc   = q_bc;
    n6.t_f    = q_f;
  end
  always_ff @(posedge clk) if (adv) c6 <= n6;

  // stage 7: b * s
  ctx_t c7;
  logic signed [BS_W-1:0] bs;
  always_ff @(posedge clk) begin
    if (adv) begin
      c7 <= c6;
      bs <= c6.b * $signed({1'b0, c6.s_main});
    end
  end

  // stage 8: t numerator and scaled e
  ctx_t c8;
  logic signed [TN_W-1:0] tn, eone;
  always_ff @(posedge clk) begin
    if (adv) begin
      c8   <= c7;
      tn   <= (TN_W)'(bs) + ((TN_W)'(c7.f) <<< FRAC_BITS);
      eone <= (TN_W)'(c7.e) <<< FRAC_BITS;
    end
  end

  cpts_div u_div_t (.clk(clk), .en(adv), .num(divw_t'(tn)), .den(divw_t'(eone)), .quo(q_t));

  ctx_t n8;
  always_comb begin
    n8        = c8;
    n8.tn_neg = (tn < 0);
    n8.tn_gt  = (tn > eone);
  end

  ctx_t dly2 [DIV_LAT];
  always_ff @(posedge clk) begin
    if (adv) begin
      dly2[0] <= n8;
      for (int i = 1; i < DIV_LAT; i++) dly2[i] <= dly2[i-1];
    end
  end

  // stage 9: pick s and t
  ctx_t   c9, x9;
  param_t s_sel, t_sel, s_n, t_n;
  always_comb begin
    x9 = dly2[DIV_LAT-1];
    priority if (x9.a_zero && x9.e_zero) begin
      s_n = '0;
      t_n = '0;
    end else if (x9.a_zero) begin
      s_n = '0;
      t_n = x9.t_f;
    end else if (x9.e_zero) begin
      s_n = x9.s_nc;
      t_n = '0;
    end else if (x9.tn_neg) begin
      s_n = x9.s_nc;
      t_n = '0;
    end else if (x9.tn_gt) begin
      s_n = x9.s_bc;
      t_n = Q_ONE;
    end else begin
      s_n = x9.s_main;
      t_n = q_t;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      c9    <= x9;
      s_sel <= s_n;
      t_sel <= t_n;
    end
  end

  // stage 10: offsets along the segments
  ctx_t c10;
  logic signed [PROD_W-1:0] m_ax, m_ay, m_bx, m_by;
  always_ff @(posedge clk) begin
    if (adv) begin
      c10  <= c9;
      m_ax <= c9.d1x * $signed({1'b0, s_sel});
      m_ay <= c9.d1y * $signed({1'b0, s_sel});
      m_bx <= c9.d2x * $signed({1'b0, t_sel});
      m_by <= c9.d2y * $signed({1'b0, t_sel});
    end
  end

  function automatic coord_t along(coord_t p, logic signed [PROD_W-1:0] pr);
    logic [PROD_W-1:0] mg;
    logic [PROD_W-1:0] m;
    mg = (pr < 0) ? -pr : pr;
    m  = mg >> FRAC_BITS;
    along = (pr < 0) ? p - coord_t'(m) : p + coord_t'(m);
  endfunction

  // stage 11: points
  coord_t pa_x, pa_y, pb_x, pb_y;
  always_ff @(posedge clk) begin
    if (adv) begin
      pa_x <= along(c10.ax0, m_ax);
      pa_y <= along(c10.ay0, m_ay);
      pb_x <= along(c10.bx0, m_bx);
      pb_y <= along(c10.by0, m_by);
    end
  end

  // stage 12: point difference
  coord_t q12_ax, q12_ay, q12_bx, q12_by;
  diff_t  dx, dy;
  always_ff @(posedge clk) begin
    if (adv) begin
      q12_ax <= pa_x;
      q12_ay <= pa_y;
      q12_bx <= pb_x;
      q12_by <= pb_y;
      dx     <= diff_t'(pa_x) - diff_t'(pb_x);
      dy     <= diff_t'(pa_y) - diff_t'(pb_y);
    end
  end

  // stage 13: squares
  coord_t q13_ax, q13_ay, q13_bx, q13_by;
  logic signed [SQ_W-1:0] sq_x, sq_y;
  always_ff @(posedge clk) begin
    if (adv) begin
      q13_ax <= q12_ax;
      q13_ay <= q12_ay;
      q13_bx <= q12_bx;
      q13_by <= q12_by;
      sq_x   <= dx * dx;
      sq_y   <= dy * dy;
    end
  end

  // stage 14: output register
  always_ff @(posedge clk) begin
    if (adv) begin
      near_a_x <= q13_ax;
      near_a_y <= q13_ay;
      near_b_x <= q13_bx;
      near_b_y <= q13_by;
      dist_sq  <= sq_x[DIST_W-1:0] + sq_y[DIST_W-1:0];
    end
  end

endmodule

`default_nettype wire

>>> sv/cpts_div.sv
// ----------------------------------------------------------------------------
// cpts_div
// Pipelined clamped ratio: 0 if num <= 0, one if num >= den, else
// floor(num * 2^FRAC_BITS / den). One restoring step per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module cpts_div import cpts_pkg::*; (
  input  logic           clk,
  input  logic           en,
  input  divw_t          num,
  input  divw_t          den,
  output logic [Q_W-1:0] quo
);

  logic [DIV_W-1:0]     rem [FRAC_BITS+1];
  logic [DIV_W-1:0]     dvs [FRAC_BITS+1];
  logic [FRAC_BITS-1:0] qp  [FRAC_BITS+1];
  logic                 lo_f [FRAC_BITS+1];
  logic                 hi_f [FRAC_BITS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= num;
      dvs[0]  <= den;
      qp[0]   <= '0;
      lo_f[0] <= (num <= 0);
      hi_f[0] <= (num >= den);
    end
  end

  for (genvar k = 0; k < FRAC_BITS; k++) begin : g_step
    logic [DIV_W-1:0] shl;
    logic             ge;
    always_comb begin
      shl = {rem[k][DIV_W-2:0], 1'b0};
      ge  = (shl >= dvs[k]);
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= ge ? shl - dvs[k] : shl;
        dvs[k+1]  <= dvs[k];
        qp[k+1]   <= {qp[k][FRAC_BITS-2:0], ge};
        lo_f[k+1] <= lo_f[k];
        hi_f[k+1] <= hi_f[k];
      end
    end
  end

  assign quo = lo_f[FRAC_BITS] ? '0 :
               hi_f[FRAC_BITS] ? Q_ONE : {1'b0, qp[FRAC_BITS]};

endmodule

`default_nettype wire

>>> sv/cpts_checker.sv
// ----------------------------------------------------------------------------
// cpts_checker
// Port-level checks of the closest-point unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module cpts_checker import cpts_pkg::*; (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire coord_t            seg_a_start_x,
  input wire coord_t            seg_a_start_y,
  input wire coord_t            seg_a_end_x,
  input wire coord_t            seg_a_end_y,
  input wire coord_t            seg_b_start_x,
  input wire coord_t            seg_b_start_y,
  input wire coord_t            seg_b_end_x,
  input wire coord_t            seg_b_end_y,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire coord_t            near_a_x,
  input wire coord_t            near_a_y,
  input wire coord_t            near_b_x,
  input wire coord_t            near_b_y,
  input wire logic [DIST_W-1:0] dist_sq
);

  localparam logic [DIST_W-1:0] DIST_MAX =
    DIST_W'(2) * DIST_W'((1 << COORD_BITS) - 1) * DIST_W'((1 << COORD_BITS) - 1);

  `CPTS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  `CPTS_ASSERT(a_ready_free, !out_valid |-> in_ready, "request refused with empty output")
  `CPTS_ASSERT(a_dist_range, out_valid |-> dist_sq <= DIST_MAX, "distance out of range")
  `CPTS_ASSERT_ALWAYS(a_rst_clear, rst |=> !out_valid, "result shown after reset")

endmodule

bind closest_points_two_segments_unit cpts_checker u_cpts_checker (.*);

`default_nettype wire

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Closest-point unit regression: directed corner pairs, then random pairs
// under random stalls on both sides, each result checked against a predictor.
// ----------------------------------------------------------------------------

module tb;
  import cpts_pkg::*;

  localparam longint ONE_S = 64'sd1 << FRAC_BITS;
  localparam int     N_RANDOM = 680;
  localparam int     CYCLE_LIMIT = 600000;
  localparam int     DRAIN_CYCLES = 80;

  typedef struct {
    coord_t           pax;
    coord_t           pay;
    coord_t           pbx;
    coord_t           pby;
    logic [DIST_W-1:0] sq_dist;
  } near_t;

  typedef logic signed [127:0] wide_t;

  // clamp n/d into [0, ONE]; d is positive
  function automatic longint clamp_q(wide_t n, wide_t d);
    if (n <= 0) return 0;
    if (n >= d) return ONE_S;
    return longint'((n * ONE_S) / d);
  endfunction

  function automatic longint walk(longint p, longint d, longint q);
    longint prod;
    longint m;
    prod = d * q;
    m = (prod < 0 ? -prod : prod) >> FRAC_BITS;
    return prod < 0 ? p - m : p + m;
  endfunction

  function automatic near_t closest_points(coord_t pt[8]);
    longint ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
    longint d1x, d1y, d2x, d2y, rx, ry, a, e, f, c, b, s, t, tn;
    longint pax, pay, pbx, pby, dx, dy;
    wide_t wa, we, wb, wc, wf, den;
    near_t r;
    ax0 = pt[0]; ay0 = pt[1]; ax1 = pt[2]; ay1 = pt[3];
    bx0 = pt[4]; by0 = pt[5]; bx1 = pt[6]; by1 = pt[7];
    d1x = ax1 - ax0; d1y = ay1 - ay0;
    d2x = bx1 - bx0; d2y = by1 - by0;
    rx = ax0 - bx0; ry = ay0 - by0;
    a = d1x * d1x + d1y * d1y;
    e = d2x * d2x + d2y * d2y;
    f = d2x * rx + d2y * ry;
    c = d1x * rx + d1y * ry;
    s = 0; t = 0;
    if (a == 0 && e == 0) begin
      s = 0; t = 0;
    end else if (a == 0) begin
      t = clamp_q(f, e);
    end else if (e == 0) begin
      s = clamp_q(-c, a);
    end else begin
      b = d1x * d2x + d1y * d2y;
      wa = a; we = e; wb = b; wc = c; wf = f;
      den = wa * we - wb * wb;
      if (den <= 0) s = 0;
      else s = clamp_q(wb * wf - wc * we, den);
      tn = b * s + f * ONE_S;
      if (tn < 0) begin
        t = 0; s = clamp_q(-c, a);
      end else if (tn > e * ONE_S) begin
        t = ONE_S; s = clamp_q(b - c, a);
      end else begin
        t = tn / e;
      end
    end
    pax = walk(ax0, d1x, s); pay = walk(ay0, d1y, s);
    pbx = walk(bx0, d2x, t); pby = walk(by0, d2y, t);
    dx = pax - pbx; dy = pay - pby;
    r.pax = coord_t'(pax); r.pay = coord_t'(pay);
    r.pbx = coord_t'(pbx); r.pby = coord_t'(pby);
    r.sq_dist = DIST_W'(dx * dx + dy * dy);
    return r;
  endfunction

  class pair_scoreboard;
    near_t pending[$];
    int    errors;

    function void note_request(coord_t pt[8]);
      pending.push_back(closest_points(pt));
    endfunction

    function void check_result(near_t got);
      near_t want;
      if (pending.size() == 0) begin
        $display("%0t: result with nothing pending", $time);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.pax !== want.pax) begin
        $display("%0t: near_a_x exp %0d got %0d", $time, want.pax, got.pax); errors++;
      end
      if (got.pay !== want.pay) begin
        $display("%0t: near_a_y exp %0d got %0d", $time, want.pay, got.pay); errors++;
      end
      if (got.pbx !== want.pbx) begin
        $display("%0t: near_b_x exp %0d got %0d", $time, want.pbx, got.pbx); errors++;
      end
      if (got.pby !== want.pby) begin
        $display("%0t: near_b_y exp %0d got %0d", $time, want.pby, got.pby); errors++;
      end
      if (got.sq_dist !== want.sq_dist) begin
        $display("%0t: dist_sq exp %0d got %0d", $time, want.sq_dist, got.sq_dist);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic out_valid;
  logic out_ready = 1'b0;
  coord_t seg_in[8] = '{default: '0};
  coord_t near_a_x, near_a_y, near_b_x, near_b_y;
  logic [DIST_W-1:0] dist_sq;
  int hold_off = 0;
  longint cycles = 0;
  pair_scoreboard board = new();

  always #4 clk = ~clk;

  closest_points_two_segments_unit u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .seg_a_start_x(seg_in[0]), .seg_a_start_y(seg_in[1]),
    .seg_a_end_x(seg_in[2]),   .seg_a_end_y(seg_in[3]),
    .seg_b_start_x(seg_in[4]), .seg_b_start_y(seg_in[5]),
    .seg_b_end_x(seg_in[6]),   .seg_b_end_y(seg_in[7]),
    .out_valid(out_valid), .out_ready(out_ready),
    .near_a_x(near_a_x), .near_a_y(near_a_y),
    .near_b_x(near_b_x), .near_b_y(near_b_y),
    .dist_sq(dist_sq)
  );

  always @(posedge clk) begin
    near_t got;
    if (!rst && in_valid && in_ready) board.note_request(seg_in);
    if (!rst && out_valid && out_ready) begin
      got.pax = near_a_x; got.pay = near_a_y;
      got.pbx = near_b_x; got.pby = near_b_y;
      got.sq_dist = dist_sq;
      board.check_result(got);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver: random stalls, with a long hold-off at random or when requested
  initial begin
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        out_ready = 1'b0;
        hold_off--;
      end else if ($urandom_range(0, 9) < 7) out_ready = 1'b1;
      else if ($urandom_range(0, 19) == 0) begin
        out_ready = 1'b0;
        hold_off = $urandom_range(10, 40);
      end else out_ready = 1'b0;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // offer one request, hold until accepted, then idle a random gap
  task automatic send_pair(coord_t pt[8]);
    int gap;
    seg_in = pt;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    gap = gap_len();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_xy(int ax0, int ay0, int ax1, int ay1,
                         int bx0, int by0, int bx1, int by1);
    coord_t pt[8];
    pt = '{coord_t'(ax0), coord_t'(ay0), coord_t'(ax1), coord_t'(ay1),
           coord_t'(bx0), coord_t'(by0), coord_t'(bx1), coord_t'(by1)};
    send_pair(pt);
  endtask

  function automatic coord_t rand_coord(int span);
    if (span == 0) return coord_t'($urandom);
    return coord_t'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  task automatic send_random();
    coord_t pt[8];
    int kind, span, k;
    kind = $urandom_range(0, 9);
    span = ($urandom_range(0, 1) == 1) ? 0 : (1 << $urandom_range(2, 14));
    foreach (pt[i]) pt[i] = rand_coord(span);
    case (kind)
      0: begin pt[2] = pt[0]; pt[3] = pt[1]; end
      1: begin pt[6] = pt[4]; pt[7] = pt[5]; end
      2: begin pt[2] = pt[0]; pt[3] = pt[1]; pt[6] = pt[4]; pt[7] = pt[5]; end
      3, 4: begin
        // parallel: B direction is a small multiple of A direction
        k = $urandom_range(0, 4) - 2;
        pt[0] = rand_coord(4000); pt[1] = rand_coord(4000);
        pt[2] = pt[0] + rand_coord(3000); pt[3] = pt[1] + rand_coord(3000);
        pt[6] = pt[4] + coord_t'(k * (pt[2] - pt[0]));
        pt[7] = pt[5] + coord_t'(k * (pt[3] - pt[1]));
      end
      default: ;
    endcase
    send_pair(pt);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // extremes and degenerate shapes
    send_xy(0, 0, 0, 0, 0, 0, 0, 0);
    send_xy(-32768, -32768, 32767, 32767, 32767, -32768, -32768, 32767);
    send_xy(-32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767);
    send_xy(32767, 32767, 32767, 32767, -32768, -32768, -32768, -32768);
    send_xy(-32768, 32767, 32767, -32768, -32768, 32767, 32767, -32768);
    send_xy(-1, -1, -1, -1, 1, 1, 1, 1);
    // one point only, projection inside and clamped at both ends
    send_xy(256, 512, 256, 512, 0, 0, 1024, 0);
    send_xy(-3000, 50, -3000, 50, 0, 0, 1024, 0);
    send_xy(5000, 50, 5000, 50, 0, 0, 1024, 0);
    send_xy(0, 0, 1024, 0, 256, 512, 256, 512);
    send_xy(0, 0, 1024, 0, -700, 9, -700, 9);
    send_xy(0, 0, 1024, 0, 4000, -9, 4000, -9);
    // parallel and collinear
    send_xy(0, 0, 1024, 0, 0, 256, 1024, 256);
    send_xy(0, 0, 1024, 0, 2048, 256, 512, 256);
    send_xy(0, 0, 1000, 1000, -500, -500, -100, -100);
    send_xy(0, 0, 100, 100, 32767, 32767, 32000, 32000);
    // crossing, t below zero, t above one
    send_xy(-1024, 0, 1024, 0, 0, -1024, 0, 1024);
    send_xy(0, 0, 1024, 0, 512, 300, 512, 2000);
    send_xy(0, 0, 1024, 0, 512, -2000, 512, -300);
    send_xy(0, 0, 1024, 0, 3000, 100, 5000, 900);
    send_xy(0, 0, 1024, 0, -3000, 100, -5000, 900);
    send_xy(-32768, 0, 32767, 1, 0, -32768, 1, 32767);

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 150) hold_off = 400; // long receiver hold-off, sender keeps going
      if (n == 400) begin
        in_valid = 1'b0;
        while (board.pending.size() != 0) @(negedge clk);
      end
      send_random();
    end
    in_valid = 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
